### src/pns_pkg.sv
package pns_pkg;

	// Field widths of the sample path.
	localparam int SampleBits  = 16;
	localparam int TargetBits  = 15;
	localparam int PeakBits    = SampleBits + 1;
	localparam int ProdBits    = 2 * SampleBits;
	localparam int MagBits     = ProdBits - 1;
	localparam int QuoBits     = SampleBits;
	localparam int StepCntBits = $clog2(QuoBits);

	localparam logic [TargetBits-1:0]  TargetReset = 15'd30000;
	localparam logic [StepCntBits-1:0] LastStep    = StepCntBits'(QuoBits - 1);

	// Pass codes carried by pass_select.
	localparam logic PassMeasure = 1'b0;
	localparam logic PassScale   = 1'b1;

	typedef struct packed {
		logic                         pass_select;
		logic signed [SampleBits-1:0] sample_in;
		logic                         last_in;
	} in_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] sample_out;
		logic                         last_out;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic measure;
		logic capture;
		logic mul;
		logic load;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

### src/pns_ctrl.sv
module pns_ctrl
	import pns_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     pass_select,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t                 state_q;
	state_t                 state_d;
	logic [StepCntBits-1:0] step_q;
	logic                   accept;

	// State register and divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (pass_select == PassScale) begin
						cmd.capture = 1'b1;
						state_d     = ST_MUL;
					end else begin
						cmd.measure = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == LastStep) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### src/pns_dp.sv
module pns_dp
	import pns_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_t                   in_item,
	input  logic                  target_we,
	input  logic [TargetBits-1:0] target_data,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_item
);

	logic [TargetBits-1:0]        target_q;
	logic [PeakBits-1:0]          peak_q;
	logic signed [SampleBits-1:0] sample_q;
	logic                         last_q;
	logic [PeakBits-1:0]          den_q;
	logic signed [ProdBits-1:0]   prod_s2;
	logic                         neg_q;
	logic                         sat_q;
	logic [PeakBits-1:0]          rem_q;
	logic [QuoBits-1:0]           quo_q;
	logic                         out_valid_q;
	out_t                         out_q;

	logic [PeakBits-1:0]          in_mag;
	logic [ProdBits-1:0]          prod_abs;
	logic [MagBits-1:0]           mag;
	logic [PeakBits-1:0]          mag_hi;
	logic [PeakBits:0]            trial;
	logic                         trial_ge;
	logic [PeakBits:0]            trial_diff;
	logic [QuoBits:0]             quo_up;
	logic [QuoBits:0]             tgt_ext;
	logic [TargetBits-1:0]        res_mag;
	logic signed [SampleBits-1:0] res;

	// Magnitude of the incoming sample for the measure pass.
	assign in_mag = in_item.sample_in[SampleBits-1]
		? PeakBits'(-{in_item.sample_in[SampleBits-1], in_item.sample_in})
		: PeakBits'({1'b0, in_item.sample_in});

	// Magnitude of the registered product and its top part for the range check.
	assign prod_abs = prod_s2[ProdBits-1] ? ProdBits'(-prod_s2) : ProdBits'(prod_s2);
	assign mag      = prod_abs[MagBits-1:0];
	assign mag_hi   = PeakBits'(mag[MagBits-1:QuoBits]);

	// One restoring division step.
	assign trial      = {rem_q, quo_q[QuoBits-1]};
	assign trial_ge   = (trial >= {1'b0, den_q});
	assign trial_diff = trial - {1'b0, den_q};

	// Floor toward minus infinity and clamp to the target.
	assign quo_up  = {1'b0, quo_q} + (QuoBits+1)'(rem_q != '0);
	assign tgt_ext = (QuoBits+1)'(target_q);
	always_comb begin
		if (sat_q) begin
			res_mag = target_q;
		end else if (neg_q) begin
			res_mag = (quo_up > tgt_ext) ? target_q : quo_up[TargetBits-1:0];
		end else begin
			res_mag = ({1'b0, quo_q} > tgt_ext) ? target_q : quo_q[TargetBits-1:0];
		end
		res = neg_q ? SampleBits'(-{1'b0, res_mag}) : SampleBits'({1'b0, res_mag});
	end

	// Target register and stored peak.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TargetReset;
			peak_q   <= '0;
		end else begin
			if (target_we) begin
				target_q <= target_data;
			end
			if (cmd.measure && (in_mag > peak_q)) begin
				peak_q <= in_mag;
			end else if (cmd.finish && last_q) begin
				peak_q <= '0;
			end
		end
	end

	// Operand capture, multiply and divide registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_item.sample_in;
			last_q   <= in_item.last_in;
		end
		if (cmd.mul) begin
			prod_s2 <= ProdBits'(sample_q) * ProdBits'($signed({1'b0, target_q}));
			den_q   <= (peak_q == '0) ? PeakBits'(1) : peak_q;
		end
		if (cmd.load) begin
			neg_q <= prod_s2[ProdBits-1];
			sat_q <= (mag_hi >= den_q);
			rem_q <= mag_hi;
			quo_q <= mag[QuoBits-1:0];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[PeakBits-1:0] : trial[PeakBits-1:0];
			quo_q <= {quo_q[QuoBits-2:0], trial_ge};
		end
	end

	// Output register holds a finished item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.sample_out <= res;
			out_q.last_out   <= last_q;
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign out_item      = out_q;

endmodule

### src/peak_normalize_samples.sv
// Two-pass peak normalizer for signed 16-bit audio. Measure-pass items
// (pass_select 0) update the stored peak magnitude and give no result.
// Scale-pass items each give floor(sample * target_peak / peak),
// with a peak of zero taken as one, clamped to plus or minus target_peak;
// the scale item marked last clears the peak. A scale item passes
// through a multiply step, a load step, 16 steps of the restoring
// divider (one quotient bit per cycle) and a finish step before its
// result is offered. The next item can be accepted in the same cycle as
// the result is offered. The finish step waits while the output
// register still holds a result that has not been taken. Input is stalled
// while a scale item is in flight. The user must write target_peak through
// target_we and target_data only while the block is idle; the block does
// not enforce this. target_peak resets to 30000.
module peak_normalize_samples
	import pns_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_item,
	input  logic                  target_we,
	input  logic [TargetBits-1:0] target_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer for capture, multiply, divide and finish.
	pns_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.pass_select (in_item.pass_select),
		.in_stall    (in_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	// Peak, multiplier, divider and output register.
	pns_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_item     (in_item),
		.target_we   (target_we),
		.target_data (target_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule

### src/pns_check.sv
module pns_check
	import pns_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input in_t  in_item,
	input logic out_valid,
	input logic out_stall,
	input out_t out_item
);

	// A waiting result item stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	// A waiting result item does not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("result item changed while stalled");

	// After a measure item the input stays open.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_item.pass_select == PassMeasure) |=> !in_stall)
		else $error("input stalled after a measure item");

	// A scale item keeps the input stalled while it is worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_item.pass_select == PassScale) |=> in_stall)
		else $error("input open during a scale item");

	// The clamp never lets the most negative code through.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.sample_out != {1'b1, {(SampleBits-1){1'b0}}}))
		else $error("result outside the clamp range");

endmodule

bind peak_normalize_samples pns_check u_pns_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

### tb/peak_normalize_samples_test.sv
module peak_normalize_samples_test;
	import pns_pkg::*;

	localparam int CycleLimit   = 600000;
	localparam int SettleCycles = 30;
	localparam int HoldCycles   = 300;
	localparam int RandomItems  = 1080;
	localparam int MaxSample    = 2 ** (SampleBits - 1) - 1;
	localparam int MinSample    = -(2 ** (SampleBits - 1));

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;
	typedef enum int {FRAME_CLEAN, FRAME_SCALE_ONLY, FRAME_MEASURE_ONLY, FRAME_NOISE} frame_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_t                   in_item = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_item;
	logic                  target_we = 1'b0;
	logic [TargetBits-1:0] target_data = '0;

	// Shadow copy of the block's state and register.
	logic [PeakBits-1:0]   peak_level;
	logic [TargetBits-1:0] target_level;
	out_t                  expected_results[$];
	logic signed [SampleBits-1:0] frame_samples[$];

	int       failures = 0;
	int       items_sent = 0;
	int       cycle_count = 0;
	int       burst_left = 0;
	bit       paced = 1'b1;
	int       hold_requests = 0;
	int       holds_seen = 0;
	int       hold_left = 0;
	int       stall_span = 0;
	rx_mode_t stall_mode = RX_FREE;

	peak_normalize_samples DUT (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.in_item,
		.out_valid,
		.out_stall,
		.out_item,
		.target_we,
		.target_data
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Give up if the run stops making progress.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Exact scaling: floor(sample * target / peak), peak of zero taken as one, then clamped.
	function automatic out_t normalize_sample(logic signed [SampleBits-1:0] s, logic last);
		out_t   res;
		longint product;
		longint divisor;
		longint quotient;
		longint limit;
		limit = longint'(target_level);
		divisor = (peak_level == '0) ? 1 : longint'(peak_level);
		product = longint'(s) * limit;
		quotient = product / divisor;
		if ((product % divisor != 0) && (product < 0))
			quotient -= 1;
		if (quotient > limit)
			quotient = limit;
		if (quotient < -limit)
			quotient = -limit;
		res.sample_out = quotient[SampleBits-1:0];
		res.last_out = last;
		return res;
	endfunction

	// Update the shadow peak or queue the normalized sample for an accepted item.
	function automatic void track_item(in_t item);
		longint magnitude;
		items_sent++;
		if (item.pass_select == PassMeasure) begin
			magnitude = longint'(item.sample_in);
			if (magnitude < 0)
				magnitude = -magnitude;
			if (magnitude > peak_level)
				peak_level = magnitude[PeakBits-1:0];
		end else begin
			expected_results.push_back(normalize_sample(item.sample_in, item.last_in));
			if (item.last_in)
				peak_level = '0;
		end
	endfunction

	// Offer one item, with bursts and gaps when pacing is on, and wait for acceptance.
	task automatic send_sample(logic pass, logic signed [SampleBits-1:0] s, logic last);
		in_t item;
		int  gap;
		item.pass_select = pass;
		item.sample_in = s;
		item.last_in = last;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = paced ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= item;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		track_item(item);
	endtask

	// Stop sending until every result is back and the block has gone quiet.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_target(logic [TargetBits-1:0] value);
		settle_block();
		target_we <= 1'b1;
		target_data <= value;
		@(posedge clk);
		target_we <= 1'b0;
		target_level = value;
	endtask

	// Send the current frame in one pass, marking its final item.
	task automatic stream_frame(logic pass);
		foreach (frame_samples[i])
			send_sample(pass, frame_samples[i], i == frame_samples.size() - 1);
	endtask

	function automatic logic signed [SampleBits-1:0] pick_sample();
		int amp;
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				return SampleBits'($urandom);
			end
			3, 4: begin
				amp = $urandom_range(1, 400);
				return SampleBits'(int'($urandom_range(0, 2 * amp)) - amp);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return SampleBits'(MinSample);
					1: return SampleBits'(MaxSample);
					2: return SampleBits'(MinSample + 1);
					default: return SampleBits'(int'($urandom_range(0, 2)) - 1);
				endcase
			end
		endcase
	endfunction

	function automatic logic [TargetBits-1:0] pick_target();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return TargetBits'(1);
			2: return '1;
			default: return TargetBits'($urandom_range(1, 2 ** TargetBits - 1));
		endcase
	endfunction

	// Check each delivered item against the oldest expected one.
	always @(posedge clk) begin
		out_t exp_item;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_results.size() == 0) begin
				$error("unexpected item: sample_out %0d last_out %0b",
					out_item.sample_out, out_item.last_out);
				failures++;
			end else begin
				exp_item = expected_results.pop_front();
				if (out_item.sample_out !== exp_item.sample_out) begin
					$error("sample_out: expected %0d, actual %0d",
						exp_item.sample_out, out_item.sample_out);
					failures++;
				end
				if (out_item.last_out !== exp_item.last_out) begin
					$error("last_out: expected %0b, actual %0b",
						exp_item.last_out, out_item.last_out);
					failures++;
				end
			end
		end
	end

	// Receiver: random stall segments, plus a long hold whenever one is requested.
	always @(posedge clk) begin
		if (hold_requests != holds_seen) begin
			holds_seen = hold_requests;
			hold_left = HoldCycles;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (stall_span == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				stall_span = $urandom_range(4, 48);
			end
			stall_span--;
			case (stall_mode)
				RX_FREE:   out_stall <= 1'b0;
				RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
				default:   out_stall <= ~out_stall;
			endcase
		end
	end

	// A scale pass straight after reset divides by one and leans on the clamp.
	task automatic test_default_target();
		paced = 1'b0;
		send_sample(PassScale, SampleBits'(MaxSample), 1'b0);
		send_sample(PassScale, SampleBits'(MinSample), 1'b0);
		send_sample(PassScale, '0, 1'b1);
		paced = 1'b1;
	endtask

	// Full-scale buffer, with a stray last mark inside the measure pass.
	task automatic test_full_scale();
		send_sample(PassMeasure, 100, 1'b1);
		send_sample(PassMeasure, SampleBits'(MinSample), 1'b0);
		send_sample(PassMeasure, SampleBits'(MaxSample), 1'b0);
		send_sample(PassMeasure, '0, 1'b1);
		send_sample(PassScale, SampleBits'(MinSample), 1'b0);
		send_sample(PassScale, SampleBits'(MaxSample), 1'b0);
		send_sample(PassScale, 1, 1'b0);
		send_sample(PassScale, -1, 1'b0);
		send_sample(PassScale, '0, 1'b0);
		send_sample(PassScale, 16384, 1'b1);
	endtask

	// Target of zero, the largest target and a target of one.
	task automatic test_target_extremes();
		set_target('0);
		send_sample(PassMeasure, 5000, 1'b1);
		send_sample(PassScale, 5000, 1'b0);
		send_sample(PassScale, -5000, 1'b1);
		set_target('1);
		send_sample(PassMeasure, -1, 1'b1);
		send_sample(PassScale, -1, 1'b0);
		send_sample(PassScale, 1, 1'b1);
		set_target(1);
		send_sample(PassMeasure, 3, 1'b1);
		send_sample(PassScale, 3, 1'b0);
		send_sample(PassScale, -3, 1'b0);
		send_sample(PassScale, 2, 1'b0);
		send_sample(PassScale, -2, 1'b1);
	endtask

	// The receiver holds off for a long stretch while the scale pass keeps coming.
	task automatic test_output_hold();
		set_target(pick_target());
		frame_samples.delete();
		repeat (12) frame_samples.push_back(pick_sample());
		stream_frame(PassMeasure);
		paced = 1'b0;
		hold_requests++;
		stream_frame(PassScale);
		paced = 1'b1;
		settle_block();
	endtask

	// Mostly well-formed two-pass buffers, with some broken or noisy ones.
	task automatic test_random_buffers();
		frame_kind_t kind;
		int          start_count;
		int          frame_index;
		int          frame_len;
		int          pick;
		start_count = items_sent;
		frame_index = 0;
		while (items_sent - start_count < RandomItems) begin
			frame_index++;
			if (frame_index % 8 == 0)
				set_target(pick_target());
			else if ($urandom_range(0, 5) == 0)
				settle_block();
			paced = ($urandom_range(0, 3) != 0);
			frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			frame_samples.delete();
			repeat (frame_len) frame_samples.push_back(pick_sample());
			pick = $urandom_range(0, 9);
			if (pick < 7)
				kind = FRAME_CLEAN;
			else if (pick == 7)
				kind = FRAME_SCALE_ONLY;
			else if (pick == 8)
				kind = FRAME_MEASURE_ONLY;
			else
				kind = FRAME_NOISE;
			case (kind)
				FRAME_CLEAN: begin
					stream_frame(PassMeasure);
					stream_frame(PassScale);
				end
				FRAME_SCALE_ONLY: begin
					stream_frame(PassScale);
				end
				FRAME_MEASURE_ONLY: begin
					stream_frame(PassMeasure);
				end
				default: begin
					foreach (frame_samples[i])
						send_sample(1'($urandom_range(0, 1)), frame_samples[i],
							1'($urandom_range(0, 1)));
				end
			endcase
		end
		paced = 1'b1;
	endtask

	initial begin
		peak_level = '0;
		target_level = TargetReset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_target();
		test_full_scale();
		test_target_extremes();
		test_output_hold();
		test_random_buffers();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
